@@ hdl/best_master_clock_selector_assert.svh @@
// Assertion macros shared by the best master clock selector modules.
`ifndef BEST_MASTER_CLOCK_SELECTOR_ASSERT_SVH
`define BEST_MASTER_CLOCK_SELECTOR_ASSERT_SVH
// Property checked on every clock edge outside reset.
`define BMCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Signal holds its value on the next edge when the condition is true.
`define BMCS_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error(msg);
`endif

@@ hdl/bmcs_pkg.sv @@
// ----------------------------------------------------------------------------
// bmcs_pkg: shared types and constants
// Types, codes and the dataset comparison used by the selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bmcs_pkg;
  localparam int unsigned MaxRecords = 8;
  localparam int unsigned SlotW = $clog2(MaxRecords);
  localparam int unsigned CountW = $clog2(MaxRecords + 1);
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam logic [7:0] ClassMasterOnly = 8'd128;

  localparam logic [CfgIdxW-1:0] RegOwnIdentity = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOwnPriority1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOwnClass = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOwnAccuracy = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOwnVariance = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOwnPriority2 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCapacity = 3'd6;

  localparam logic [2:0] StListening = 3'd0;
  localparam logic [2:0] StMaster = 3'd1;
  localparam logic [2:0] StPassive = 3'd2;
  localparam logic [2:0] StSlave = 3'd3;
  localparam logic [2:0] StNone = 3'd4;

  localparam logic CmdAdd = 1'b0;
  localparam logic CmdRun = 1'b1;

  typedef struct packed {
    logic        command;
    logic [63:0] sender_identity;
    logic [15:0] sender_port;
    logic [63:0] gm_identity;
    logic [7:0]  gm_priority1;
    logic [7:0]  gm_class;
    logic [7:0]  gm_accuracy;
    logic [15:0] gm_variance;
    logic [7:0]  gm_priority2;
    logic [15:0] hops;
    logic        now_listening;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  decided_state;
    logic [2:0]  best_slot;
    logic        master_changed;
    logic [15:0] new_hops;
    logic [2:0]  written_slot;
    logic        was_known;
    logic [3:0]  records_held;
  } out_item_t;

  // Dataset of one record as seen by the comparator.
  typedef struct packed {
    logic [63:0] gm;
    logic [47:0] quality;
    logic [15:0] hops;
    logic [63:0] sender;
  } dataset_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input item
    logic search_init; // start the sender search
    logic search_step; // test one slot
    logic add_commit;  // write the record
    logic scan_init;   // start the best record scan
    logic scan_step;   // compare one slot against the best
    logic decide;      // compare own dataset and set the result
  } dp_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic is_run;
    logic search_done;
    logic scan_done;
  } dp_sts_t;

  // Returns 2'b01 if a is better, 2'b10 if b is better, 2'b00 undecided.
  function automatic logic [1:0] compare_sets(input dataset_t a, input dataset_t b,
                                              input logic [63:0] own_id);
    logic [16:0] ha1;
    logic [16:0] hb1;
    logic [1:0]  r;
    ha1 = {1'b0, a.hops} + 17'd1;
    hb1 = {1'b0, b.hops} + 17'd1;
    if (a.gm != b.gm) begin
      if (a.quality > b.quality) r = 2'b10;
      else if (b.quality > a.quality) r = 2'b01;
      else r = (a.gm > b.gm) ? 2'b10 : 2'b01;
    end else if ({1'b0, a.hops} > hb1) begin
      r = 2'b10;
    end else if ({1'b0, b.hops} > ha1) begin
      r = 2'b01;
    end else if (a.hops > b.hops) begin
      r = (a.sender == own_id) ? 2'b00 : 2'b10;
    end else if (a.hops < b.hops) begin
      r = (b.sender == own_id) ? 2'b00 : 2'b01;
    end else if (a.sender > b.sender) begin
      r = 2'b10;
    end else if (a.sender < b.sender) begin
      r = 2'b01;
    end else begin
      r = 2'b00;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

@@ hdl/bmcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmcs_ctrl: step sequencer
// Accepts one item at a time: search and write steps for an add, scan and
// decision steps for a run; then holds the result until it is transferred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "best_master_clock_selector_assert.svh"
module bmcs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bmcs_pkg::dp_cmd_t      cmd_o,
  input  wire bmcs_pkg::dp_sts_t sts_i
);
  import bmcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SEARCH, S_WRITE, S_SCAN, S_DECIDE, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Command decode from the current state.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:     cmd_o.load = in_valid_i;
      S_DISPATCH: begin
        cmd_o.search_init = !sts_i.is_run;
        cmd_o.scan_init = sts_i.is_run;
      end
      S_SEARCH:   cmd_o.search_step = !sts_i.search_done;
      S_WRITE:    cmd_o.add_commit = 1'b1;
      S_SCAN:     cmd_o.scan_step = !sts_i.scan_done;
      S_DECIDE:   cmd_o.decide = 1'b1;
      S_OUT:      cmd_o = '0;
      default:    cmd_o = '0;
    endcase
  end

  // State register and registered output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DISPATCH;
        S_DISPATCH: state_q <= sts_i.is_run ? S_SCAN : S_SEARCH;
        S_SEARCH: if (sts_i.search_done) state_q <= S_WRITE;
        S_WRITE: begin
          state_q <= S_OUT;
          out_valid_q <= 1'b1;
        end
        S_SCAN: if (sts_i.scan_done) state_q <= S_DECIDE;
        S_DECIDE: begin
          state_q <= S_OUT;
          out_valid_q <= 1'b1;
        end
        S_OUT: if (out_ready_i) begin
          state_q <= S_IDLE;
          out_valid_q <= 1'b0;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `BMCS_ASSERT(a_no_overlap, clk_i, rst_ni, !(in_ready_o && out_valid_o),
    "input taken while a result is pending")
  `BMCS_ASSERT(a_out_follows, clk_i, rst_ni,
    (cmd_o.add_commit || cmd_o.decide) |=> out_valid_o, "result not presented")
  `BMCS_ASSERT(a_one_cmd, clk_i, rst_ni, $onehot0(cmd_o), "several commands at once")
endmodule
`default_nettype wire

@@ hdl/bmcs_datapath.sv @@
// ----------------------------------------------------------------------------
// bmcs_datapath: record table and comparator
// Holds the foreign master table, the configuration, the parent identity and
// one shared dataset comparator used a slot per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "best_master_clock_selector_assert.svh"
module bmcs_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [bmcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bmcs_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire bmcs_pkg::in_item_t        in_item_i,
  input  wire bmcs_pkg::dp_cmd_t         cmd_i,
  output bmcs_pkg::dp_sts_t              sts_o,
  output bmcs_pkg::out_item_t            out_item_o
);
  import bmcs_pkg::*;

  // Configuration registers.
  logic [63:0] own_id_q;
  logic [7:0]  own_p1_q, own_cls_q, own_acc_q, own_p2_q;
  logic [15:0] own_var_q;
  logic [3:0]  cap_q;

  // Record table, one register per slot.
  logic [63:0] rec_sid_q [MaxRecords];
  logic [15:0] rec_sport_q [MaxRecords];
  logic [63:0] rec_gm_q [MaxRecords];
  logic [47:0] rec_q_q [MaxRecords];
  logic [15:0] rec_hops_q [MaxRecords];
  logic [15:0] rec_seen_q [MaxRecords];

  logic [CountW-1:0] valid_q;
  logic [SlotW-1:0]  ins_q, best_q, idx_q, j_q;
  logic [CountW-1:0] cnt_q;
  logic              known_q;
  logic [63:0]       par_id_q;
  logic [15:0]       par_port_q;
  in_item_t          item_q;
  out_item_t         out_q;

  logic [CountW-1:0] cap_eff;
  dataset_t          ds_i, ds_best, ds_own;
  logic [1:0]        cmp;
  logic [SlotW-1:0]  j_next;
  logic              hit;
  logic [3:0]        ins_inc;
  logic [SlotW-1:0]  ins_next;
  logic [SlotW-1:0]  wr_slot;
  logic [2:0]        dec_state;
  logic [15:0]       dec_hops;
  logic              dec_changed;

  // Effective capacity clipped to 1..MaxRecords.
  always_comb begin
    if (cap_q == 4'd0) cap_eff = CountW'(1);
    else if ({1'b0, cap_q} > 5'(MaxRecords)) cap_eff = CountW'(MaxRecords);
    else cap_eff = CountW'(cap_q);
  end

  // Ring pointer advance: the incremented pointer reduced modulo the capacity.
  // The pointer may sit above a lowered capacity, so the sum runs up to 8.
  always_comb begin
    ins_inc = {1'b0, ins_q} + 4'd1;
    unique case (cap_eff)
      4'd1: ins_next = '0;
      4'd2: ins_next = {2'b00, ins_inc[0]};
      4'd3: begin
        if (ins_inc >= 4'd6) ins_next = SlotW'(ins_inc - 4'd6);
        else if (ins_inc >= 4'd3) ins_next = SlotW'(ins_inc - 4'd3);
        else ins_next = ins_inc[2:0];
      end
      4'd4: ins_next = {1'b0, ins_inc[1:0]};
      default: ins_next = (ins_inc >= cap_eff) ? SlotW'(ins_inc - cap_eff) : ins_inc[2:0];
    endcase
  end

  // Shared comparator: candidate slot against the current best, or own against best.
  always_comb begin
    ds_i = '{gm: rec_gm_q[idx_q], quality: rec_q_q[idx_q], hops: rec_hops_q[idx_q],
             sender: rec_sid_q[idx_q]};
    ds_best = '{gm: rec_gm_q[best_q], quality: rec_q_q[best_q],
                hops: rec_hops_q[best_q], sender: rec_sid_q[best_q]};
    ds_own = '{gm: own_id_q, quality: {own_p1_q, own_cls_q, own_acc_q, own_var_q, own_p2_q},
               hops: 16'd0, sender: own_id_q};
    cmp = compare_sets(cmd_i.decide ? ds_own : ds_i, ds_best, own_id_q);
  end

  // Port state decision from the record count, the own-versus-best comparison and own class.
  always_comb begin
    dec_state = StSlave;
    dec_hops = '0;
    dec_changed = 1'b0;
    if (valid_q == '0 && item_q.now_listening) begin
      dec_state = StListening;
    end else if (cmp == 2'b01) begin
      dec_state = StMaster;
    end else if (own_cls_q < ClassMasterOnly) begin
      dec_state = StPassive;
    end else begin
      dec_hops = (rec_hops_q[best_q] != 16'hFFFF) ? rec_hops_q[best_q] + 16'd1 : 16'hFFFF;
      dec_changed = !(par_id_q == rec_sid_q[best_q] && par_port_q == rec_sport_q[best_q]);
    end
  end

  // Search match and wrap over the valid records.
  assign hit = (rec_sid_q[j_q] == item_q.sender_identity) &&
               (rec_sport_q[j_q] == item_q.sender_port);
  assign j_next = ({1'b0, j_q} + 1'b1 >= CountW'(valid_q)) ? '0 : j_q + 1'b1;
  assign wr_slot = known_q ? j_q : ins_q;

  assign sts_o.is_run = item_q.command == CmdRun;
  assign sts_o.search_done = (cnt_q >= valid_q) || known_q;
  assign sts_o.scan_done = ({1'b0, idx_q} >= CountW'(valid_q)) || (idx_q == '0);
  assign out_item_o = out_q;

  // Input item register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
  end

  // Record table, control state, configuration, parent tracking and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0; own_p1_q <= 8'd128; own_cls_q <= 8'd248; own_acc_q <= 8'd254;
      own_var_q <= 16'hFFFF; own_p2_q <= 8'd128; cap_q <= 4'd8;
      valid_q <= '0; ins_q <= '0; best_q <= '0; idx_q <= '0; j_q <= '0; cnt_q <= '0;
      known_q <= 1'b0; par_id_q <= '0; par_port_q <= '0; out_q <= '0;
      for (int k = 0; k < MaxRecords; k++) begin
        rec_sid_q[k] <= '0; rec_sport_q[k] <= '0; rec_gm_q[k] <= '0;
        rec_q_q[k] <= '0; rec_hops_q[k] <= '0; rec_seen_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegOwnIdentity:  own_id_q <= cfg_data_i;
          RegOwnPriority1: own_p1_q <= cfg_data_i[7:0];
          RegOwnClass:     own_cls_q <= cfg_data_i[7:0];
          RegOwnAccuracy:  own_acc_q <= cfg_data_i[7:0];
          RegOwnVariance:  own_var_q <= cfg_data_i[15:0];
          RegOwnPriority2: own_p2_q <= cfg_data_i[7:0];
          RegCapacity:     cap_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (cmd_i.search_init) begin
        j_q <= ({1'b0, best_q} < CountW'(valid_q)) ? best_q : '0;
        cnt_q <= '0;
        known_q <= 1'b0;
      end
      if (cmd_i.search_step) begin
        if (hit) known_q <= 1'b1;
        else begin
          j_q <= j_next;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.add_commit) begin
        rec_sid_q[wr_slot] <= item_q.sender_identity;
        rec_sport_q[wr_slot] <= item_q.sender_port;
        rec_gm_q[wr_slot] <= item_q.gm_identity;
        rec_q_q[wr_slot] <= {item_q.gm_priority1, item_q.gm_class,
          item_q.gm_accuracy, item_q.gm_variance, item_q.gm_priority2};
        rec_hops_q[wr_slot] <= item_q.hops;
        if (!known_q) rec_seen_q[ins_q] <= '0;
        else if (rec_seen_q[j_q] != 16'hFFFF) rec_seen_q[j_q] <= rec_seen_q[j_q] + 16'd1;
        if (!known_q) begin
          if (valid_q < cap_eff) valid_q <= valid_q + 1'b1;
          ins_q <= ins_next;
        end
        out_q <= '{decided_state: StNone, best_slot: '0, master_changed: 1'b0,
                   new_hops: '0, written_slot: wr_slot, was_known: known_q,
                   records_held: (!known_q && valid_q < cap_eff) ?
                                 4'(valid_q + 1'b1) : 4'(valid_q)};
      end
      if (cmd_i.scan_init) begin
        best_q <= '0;
        idx_q <= SlotW'(1);
      end
      if (cmd_i.scan_step) begin
        if (cmp == 2'b01) best_q <= idx_q;
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.decide) begin
        out_q <= '{decided_state: dec_state, best_slot: best_q, master_changed: dec_changed,
                   new_hops: dec_hops, written_slot: '0, was_known: 1'b0,
                   records_held: 4'(valid_q)};
        if (dec_state == StMaster) begin
          par_id_q <= own_id_q;
          par_port_q <= '0;
        end else if (dec_state == StSlave) begin
          par_id_q <= rec_sid_q[best_q];
          par_port_q <= rec_sport_q[best_q];
        end
      end
    end
  end

  `BMCS_ASSERT(a_valid_cap, clk_i, rst_ni, valid_q <= CountW'(MaxRecords),
    "record count above table size")
  `BMCS_HOLD(a_table_hold, clk_i, rst_ni, !cmd_i.add_commit && !cmd_i.decide, valid_q,
    "record count moved outside a write")
  `BMCS_ASSERT(a_best_valid, clk_i, rst_ni,
    cmd_i.decide |-> (valid_q == '0 || {1'b0, best_q} < valid_q), "best slot not valid")
endmodule
`default_nettype wire

@@ hdl/best_master_clock_selector.sv @@
// ----------------------------------------------------------------------------
// best_master_clock_selector: one-port best master clock selection
// Foreign master table with add and run commands and the state decision.
// ----------------------------------------------------------------------------
// One item is handled at a time. An add searches the table for the sender and
// then writes the record; a run scans the valid records after the first with the
// single shared dataset comparator and then compares the own dataset with the best.
// The result waits in an output register until it is transferred; the next
// item is taken after that.
`timescale 1ns / 1ps
`default_nettype none
module best_master_clock_selector (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bmcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bmcs_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire bmcs_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output bmcs_pkg::out_item_t                out_data_o
);
  import bmcs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  bmcs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  // Table and comparator.
  bmcs_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_item_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .out_item_o(out_data_o)
  );
endmodule
`default_nettype wire
